// ===== src/byte_pair_selective_histogram_core_macros.svh =====
`ifndef BYTE_PAIR_SELECTIVE_HISTOGRAM_CORE_MACROS_SVH
`define BYTE_PAIR_SELECTIVE_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication on clk, off while arst_n is low.
`define BPSH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, off while arst_n is low.
`define BPSH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bpsh_pkg.sv =====
package bpsh_pkg;

	localparam int BYTE_WIDTH   = 8;
	localparam int SEL_WIDTH    = 2;
	localparam int SKIP_WIDTH   = 16;
	localparam int PAIRS_WIDTH  = 41;
	localparam int CFG_WIDTH    = 41;
	localparam int CFG_IDX_WIDTH = 1;
	localparam int VALUE_WIDTH  = 64;
	localparam int ADDR_WIDTH   = SEL_WIDTH + 2 * BYTE_WIDTH;
	localparam int STORE_DEPTH  = 1 << ADDR_WIDTH;

	localparam logic [SKIP_WIDTH-1:0]  SKIP_RESET  = 16'd1024;
	localparam logic [PAIRS_WIDTH-1:0] PAIRS_RESET = 41'd1 << 34;

	localparam logic [BYTE_WIDTH-1:0] BYTE_ZERO = 8'h00;
	localparam logic [BYTE_WIDTH-1:0] BYTE_FULL = 8'hff;

	localparam logic [SEL_WIDTH-1:0] TBL_PREV_ZERO = 2'd0;
	localparam logic [SEL_WIDTH-1:0] TBL_PREV_FULL = 2'd1;
	localparam logic [SEL_WIDTH-1:0] TBL_CUR_FULL  = 2'd2;
	localparam logic [SEL_WIDTH-1:0] TBL_PLAIN     = 2'd3;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_SKIP_COUNT  = 1'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_BATCH_PAIRS = 1'd1;

	typedef enum logic [1:0] {
		REQ_BYTE  = 2'd0,
		REQ_START = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_e_t;

	typedef enum logic [1:0] {
		ST_COUNTED = 2'd0,
		ST_IGNORED = 2'd1,
		ST_READ    = 2'd2,
		ST_STARTED = 2'd3
	} status_t;

	typedef enum logic {
		PH_CLEAR,
		PH_RUN
	} phase_t;

	typedef struct packed {
		logic                  bump;
		status_t               status;
		logic [ADDR_WIDTH-1:0] addr;
	} op_t;

	typedef struct packed {
		logic                  en;
		logic [ADDR_WIDTH-1:0] addr;
	} wr_t;

endpackage

// ===== src/bpsh_req_if.sv =====
interface bpsh_req_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         req_type;
	logic [bpsh_pkg::BYTE_WIDTH-1:0]    byte_value;
	logic [bpsh_pkg::SEL_WIDTH-1:0]     table_select;
	logic [bpsh_pkg::BYTE_WIDTH-1:0]    row_index;
	logic [bpsh_pkg::BYTE_WIDTH-1:0]    column_index;

	modport source (output valid, req_type, byte_value, table_select, row_index,
		column_index, input ready);
	modport sink (input valid, req_type, byte_value, table_select, row_index,
		column_index, output ready);
endinterface

// ===== src/bpsh_rsp_if.sv =====
interface bpsh_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       status;
	logic [bpsh_pkg::VALUE_WIDTH-1:0] count_value;

	modport source (output valid, status, count_value, input ready);
	modport sink (input valid, status, count_value, output ready);
endinterface

// ===== src/bpsh_ram.sv =====
module bpsh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/bpsh_ctrl.sv =====
module bpsh_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bpsh_req_if.sink                             req,
	input  logic                                 cfg_we,
	input  logic [bpsh_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [bpsh_pkg::CFG_WIDTH-1:0]       cfg_data,
	input  logic                                 take,
	output logic                                 accept,
	output bpsh_pkg::op_t                        op,
	output bpsh_pkg::wr_t                        clr
);

	bpsh_pkg::phase_t                        phase_q, phase_d;
	logic [bpsh_pkg::ADDR_WIDTH-1:0]         clr_addr_q;

	logic [bpsh_pkg::SKIP_WIDTH-1:0]         skip_q;
	logic [bpsh_pkg::PAIRS_WIDTH-1:0]        batch_q;

	logic [bpsh_pkg::BYTE_WIDTH-1:0]         prev_q, prev_d;
	logic                                    have_q, have_d;
	logic [bpsh_pkg::SKIP_WIDTH-1:0]         warm_q, warm_d;
	logic [bpsh_pkg::PAIRS_WIDTH-1:0]        pairs_q, pairs_d;
	logic [bpsh_pkg::BYTE_WIDTH-1:0]         pos;

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			bpsh_pkg::PH_CLEAR: begin
				if (&clr_addr_q) begin
					phase_d = bpsh_pkg::PH_RUN;
				end
			end
			bpsh_pkg::PH_RUN: begin
				phase_d = bpsh_pkg::PH_RUN;
			end
			default: begin
				phase_d = bpsh_pkg::PH_CLEAR;
			end
		endcase
	end

	always_comb begin
		clr.en    = (phase_q == bpsh_pkg::PH_CLEAR);
		clr.addr  = clr_addr_q;
		req.ready = (phase_q == bpsh_pkg::PH_RUN) && take;
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bpsh_pkg::PH_CLEAR;
			clr_addr_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q == bpsh_pkg::PH_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= bpsh_pkg::SKIP_RESET;
			batch_q <= bpsh_pkg::PAIRS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bpsh_pkg::REG_SKIP_COUNT:  skip_q  <= cfg_data[bpsh_pkg::SKIP_WIDTH-1:0];
				bpsh_pkg::REG_BATCH_PAIRS: batch_q <= cfg_data[bpsh_pkg::PAIRS_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign pos = pairs_q[bpsh_pkg::BYTE_WIDTH-1:0];

	// Decode the item and work out the batch state it leaves behind.
	always_comb begin
		op.bump   = 1'b0;
		op.status = bpsh_pkg::ST_IGNORED;
		op.addr   = {req.table_select, req.row_index, req.column_index};
		prev_d    = prev_q;
		have_d    = have_q;
		warm_d    = warm_q;
		pairs_d   = pairs_q;
		case (bpsh_pkg::req_e_t'(req.req_type))
			bpsh_pkg::REQ_BYTE: begin
				if (warm_q != '0) begin
					warm_d = warm_q - 1'b1;
				end else if (!have_q) begin
					prev_d = req.byte_value;
					have_d = 1'b1;
				end else if (pairs_q < batch_q) begin
					op.bump   = 1'b1;
					op.status = bpsh_pkg::ST_COUNTED;
					if (prev_q == bpsh_pkg::BYTE_ZERO) begin
						op.addr = {bpsh_pkg::TBL_PREV_ZERO, pos, req.byte_value};
					end else if (prev_q == bpsh_pkg::BYTE_FULL) begin
						op.addr = {bpsh_pkg::TBL_PREV_FULL, pos, req.byte_value};
					end else if (req.byte_value == bpsh_pkg::BYTE_FULL) begin
						op.addr = {bpsh_pkg::TBL_CUR_FULL, pos, prev_q};
					end else begin
						op.addr = {bpsh_pkg::TBL_PLAIN, prev_q, req.byte_value};
					end
					pairs_d = pairs_q + 1'b1;
					prev_d  = req.byte_value;
				end
			end
			bpsh_pkg::REQ_START: begin
				op.status = bpsh_pkg::ST_STARTED;
				warm_d    = skip_q;
				have_d    = 1'b0;
				pairs_d   = '0;
			end
			bpsh_pkg::REQ_READ: begin
				op.status = bpsh_pkg::ST_READ;
			end
			default: begin
				op.status = bpsh_pkg::ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			have_q  <= 1'b0;
			warm_q  <= '0;
			pairs_q <= '0;
		end else if (accept) begin
			prev_q  <= prev_d;
			have_q  <= have_d;
			warm_q  <= warm_d;
			pairs_q <= pairs_d;
		end
	end

endmodule

// ===== src/bpsh_update.sv =====
`include "byte_pair_selective_histogram_core_macros.svh"

module bpsh_update #(
	parameter int COUNT_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  bpsh_pkg::op_t                       op,
	input  logic [COUNT_WIDTH-1:0]              rd_data,
	input  logic                                rsp_ready,
	output logic                                take,
	output bpsh_pkg::wr_t                       wr,
	output logic [COUNT_WIDTH-1:0]              wr_data,
	output logic                                rsp_valid,
	output logic [1:0]                          rsp_status,
	output logic [bpsh_pkg::VALUE_WIDTH-1:0]    rsp_value
);

	logic                                valid_s1;
	bpsh_pkg::op_t                       op_s1;
	logic                                adv;

	logic                                wr_valid_q;
	logic [bpsh_pkg::ADDR_WIDTH-1:0]     wr_addr_q;
	logic [COUNT_WIDTH-1:0]              wr_data_q;

	logic [COUNT_WIDTH-1:0]              cur_count;

	logic                                out_valid_q;
	bpsh_pkg::status_t                   out_status_q;
	logic [bpsh_pkg::VALUE_WIDTH-1:0]    out_value_q;

	assign adv  = valid_s1 && (!out_valid_q || rsp_ready);
	assign take = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
		end
	end

	// The memory read for this item raced the previous write; take the written value.
	assign cur_count = (wr_valid_q && (wr_addr_q == op_s1.addr)) ? wr_data_q : rd_data;

	assign wr.en   = adv && op_s1.bump;
	assign wr.addr = op_s1.addr;
	assign wr_data = (&cur_count) ? cur_count : cur_count + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (wr.en) begin
			wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			wr_addr_q <= wr.addr;
			wr_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_status_q <= op_s1.status;
			out_value_q  <= (op_s1.status == bpsh_pkg::ST_READ) ?
				bpsh_pkg::VALUE_WIDTH'(cur_count) : '0;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_value  = out_value_q;

	`BPSH_ASSERT_NOW(a_no_overrun, accept, !valid_s1 || adv, "item accepted over a held item")
	`BPSH_ASSERT_NOW(a_read_no_bump, valid_s1 && op_s1.status == bpsh_pkg::ST_READ, !op_s1.bump, "read item marked for update")
	`BPSH_ASSERT_NEXT(a_bump_nonzero, wr.en, wr_valid_q && wr_data_q != '0, "updated count is zero")
	`BPSH_ASSERT_NEXT(a_result_lands, adv, out_valid_q && out_status_q == $past(op_s1.status), "result not registered")

endmodule

// ===== src/byte_pair_selective_histogram_core.sv =====
// Byte-pair histogram: one item per clock in steady state while rsp.ready stays high;
// results pass stage 1 and then the output register. Pace is set by the count memory,
// 262144 entries with one read and one write port; each pair is a read-modify-write,
// and a pair that hits the count written by the pair just before it takes that count
// from a forwarding register. After reset a clearing pass zeroes the memory, one entry
// per cycle, with req.ready low; configuration writes are taken throughout.
module byte_pair_selective_histogram_core #(
	parameter int COUNT_WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bpsh_req_if.sink                             req,
	bpsh_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [bpsh_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [bpsh_pkg::CFG_WIDTH-1:0]       cfg_data
);

	logic                     take;
	logic                     accept;
	bpsh_pkg::op_t            op;
	bpsh_pkg::wr_t            clr;
	bpsh_pkg::wr_t            upd;
	logic [COUNT_WIDTH-1:0]   upd_data;
	logic [COUNT_WIDTH-1:0]   rd_data;

	logic                              ram_we;
	logic [bpsh_pkg::ADDR_WIDTH-1:0]   ram_waddr;
	logic [COUNT_WIDTH-1:0]            ram_wdata;

	bpsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.accept    (accept),
		.op        (op),
		.clr       (clr)
	);

	// Clearing pass owns the write port until it ends.
	assign ram_we    = clr.en || upd.en;
	assign ram_waddr = clr.en ? clr.addr : upd.addr;
	assign ram_wdata = clr.en ? '0 : upd_data;

	bpsh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (bpsh_pkg::STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (op.addr),
		.rdata (rd_data)
	);

	bpsh_update #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.rd_data    (rd_data),
		.rsp_ready  (rsp.ready),
		.take       (take),
		.wr         (upd),
		.wr_data    (upd_data),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_value  (rsp.count_value)
	);

endmodule
